@@ hdl/cms_pkg.sv @@
// Package: constants and types shared by the count-min sketch query unit.
package cms_pkg;

	localparam int unsigned TableDepthDefault = 4;
	localparam int unsigned TableWidthDefault = 1024;
	localparam int unsigned MaxRows = 4;
	localparam int unsigned CfgAddrW = 5;

	// hash prime; the reduction in cms_hash relies on it being 2^32 plus a small fold
	localparam logic [63:0] LongPrime = 64'd4294967311;
	localparam logic [63:0] PrimeFold = LongPrime - 64'h1_0000_0000;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_ESTIMATE = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture input beat
		logic hash_go;   // start hashing row
		logic mem_wr;    // write bucket
		logic cmp;       // fold read data into minimum
		logic emit;      // present result
		logic upd_inc;   // advance update count
		logic [1:0] row; // row under work
	} cms_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic hash_done;
		logic op;
		logic clr_done;
	} cms_stat_t;

endpackage

@@ hdl/cms_ram.sv @@
// Generic single-port RAM with registered read.
module cms_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

@@ hdl/cms_hash.sv @@
// Iterative row hash: 64-bit multiply-add in two halves, prime fold, bucket reduction.
module cms_hash import cms_pkg::*; #(
	parameter int unsigned NUM_BUCKETS = TableWidthDefault
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            go,
	input  logic [63:0]                     key,
	input  logic [31:0]                     mult,
	input  logic [31:0]                     offs,
	output logic                            done,
	output logic [$clog2(NUM_BUCKETS)-1:0]  bucket
);
	localparam int unsigned BW = $clog2(NUM_BUCKETS);
	localparam int unsigned SH = 32 + BW;
	// rounded-up reciprocal of the bucket count, exact for any 32-bit dividend
	localparam logic [63:0] Recip =
		((64'd1 << SH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
	// 2^32 modulo the bucket count, for hashes at or above 2^32
	localparam logic [16:0] Wrap = 17'((64'd1 << 32) % 64'(NUM_BUCKETS));
	localparam logic [17:0] NB = 18'(NUM_BUCKETS);
	// fold-many primes keep the first fold non-negative
	localparam logic [37:0] PrimeBias = 38'(LongPrime * PrimeFold);

	typedef enum logic [3:0] {
		H_IDLE, H_MLO, H_MHI, H_PF1, H_PF2, H_WQ, H_WR, H_WF, H_DONE
	} hst_t;
	hst_t st_q;
	logic [63:0] prod_q;   // wrapping multiply-add
	logic [37:0] fold_q;   // first fold, below 17 primes
	logic [32:0] rem_q;    // hash modulo the prime
	logic [31:0] quo_q;    // low word over bucket count
	logic [16:0] part_q;   // low word modulo bucket count
	logic [BW-1:0] bkt_q;
	logic [63:0] lo_prod;
	logic [31:0] hi_prod;
	logic [37:0] pf1_val;
	logic [33:0] pf2_val;
	logic [64:0] wq_prod;
	logic [64:0] wq_shift;
	logic [48:0] wr_prod;
	logic [31:0] wr_diff;
	logic [17:0] wf_sum;
	logic [17:0] wf_sub;

	assign lo_prod = 64'(mult) * 64'(key[31:0]);
	assign hi_prod = mult * key[63:32];
	// 2^32 is -fold modulo the prime: hi*2^32 + lo -> lo - fold*hi, biased positive
	assign pf1_val = 38'(prod_q[31:0]) + PrimeBias
		- 38'(prod_q[63:32]) * 38'(PrimeFold);
	assign pf2_val = {2'b00, fold_q[31:0]} - 34'(fold_q[37:32]) * 34'(PrimeFold);
	assign wq_prod = 65'(rem_q[31:0]) * 65'(Recip[32:0]);
	assign wq_shift = wq_prod >> SH;
	assign wr_prod = 49'(quo_q) * 49'(NUM_BUCKETS);
	assign wr_diff = rem_q[31:0] - wr_prod[31:0];
	assign wf_sum = {1'b0, part_q} + (rem_q[32] ? {1'b0, Wrap} : 18'd0);
	assign wf_sub = wf_sum - NB;

	// one step per cycle: two partial products, two prime folds, three bucket steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= H_IDLE;
		end else begin
			case (st_q)
				H_IDLE: if (go) st_q <= H_MLO;
				H_MLO: begin
					prod_q <= lo_prod + 64'(offs);
					st_q <= H_MHI;
				end
				H_MHI: begin
					prod_q <= prod_q + {hi_prod, 32'd0};
					st_q <= H_PF1;
				end
				H_PF1: begin
					fold_q <= pf1_val;
					st_q <= H_PF2;
				end
				H_PF2: begin
					// quotient estimate may overshoot by one prime
					if (pf2_val[33])
						rem_q <= 33'(pf2_val + 34'(LongPrime));
					else
						rem_q <= pf2_val[32:0];
					st_q <= H_WQ;
				end
				H_WQ: begin
					quo_q <= wq_shift[31:0];
					st_q <= H_WR;
				end
				H_WR: begin
					part_q <= wr_diff[16:0];
					st_q <= H_WF;
				end
				H_WF: begin
					bkt_q <= (wf_sum >= NB) ? BW'(wf_sub) : BW'(wf_sum);
					st_q <= H_DONE;
				end
				H_DONE: st_q <= H_IDLE;
				default: st_q <= H_IDLE;
			endcase
		end
	end

	assign done = (st_q == H_DONE);
	assign bucket = bkt_q;
endmodule

@@ hdl/cms_datapath.sv @@
// Datapath: config registers, input capture, hash unit, counter RAM, minimum.
module cms_datapath import cms_pkg::*; #(
	parameter int unsigned NUM_ROWS = TableDepthDefault,
	parameter int unsigned NUM_BUCKETS = TableWidthDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cms_cmd_t            cmd,
	output cms_stat_t           stat,
	input  logic                clr_en,
	input  logic                opcode,
	input  logic [63:0]         item_key,
	input  logic [31:0]         count_row0,
	input  logic [31:0]         count_row1,
	input  logic [31:0]         count_row2,
	input  logic [31:0]         count_row3,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_idx,
	input  logic [31:0]         cfg_wdata,
	output logic [31:0]         cfg_rdata,
	output logic                strobe,
	output logic [31:0]         min_estimate,
	output logic [31:0]         updates_seen
);
	localparam int unsigned BW = $clog2(NUM_BUCKETS);
	localparam int unsigned RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
	localparam int unsigned Depth = NUM_ROWS << BW;
	localparam int unsigned AW = $clog2(Depth);
	localparam int unsigned CW = AW + 1;

	logic [31:0] mult_q [MaxRows];
	logic [31:0] offs_q [MaxRows];
	logic        op_q;
	logic [63:0] key_q;
	logic [31:0] cnt_q [MaxRows];
	logic [31:0] min_q;
	logic [31:0] upd_q;
	logic [BW-1:0] bucket_q;
	logic [BW-1:0] bucket;
	logic        hdone;
	logic [CW-1:0] clr_q;
	logic [AW-1:0] addr;
	logic        we;
	logic [31:0] wdata;
	logic [31:0] rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MaxRows; i++) begin
				mult_q[i] <= 32'd1;
				offs_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_idx[0]) offs_q[cfg_idx[2:1]] <= cfg_wdata;
			else mult_q[cfg_idx[2:1]] <= cfg_wdata;
		end
	end
	assign cfg_rdata = cfg_idx[0] ? offs_q[cfg_idx[2:1]] : mult_q[cfg_idx[2:1]];

	// input beat capture, running minimum and hash bucket capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode;
			key_q <= item_key;
			cnt_q[0] <= count_row0;
			cnt_q[1] <= count_row1;
			cnt_q[2] <= count_row2;
			cnt_q[3] <= count_row3;
			min_q <= '1;
		end else if (cmd.cmp && rdata < min_q) begin
			min_q <= rdata;
		end
		if (hdone) bucket_q <= bucket;
	end

	cms_hash #(.NUM_BUCKETS(NUM_BUCKETS)) u_hash (
		.clk(clk), .arst_n(arst_n), .go(cmd.hash_go), .key(key_q),
		.mult(mult_q[cmd.row]), .offs(offs_q[cmd.row]),
		.done(hdone), .bucket(bucket)
	);

	// clearing sweep after reset and update counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			upd_q <= '0;
		end else begin
			if (clr_en) clr_q <= clr_q + CW'(1);
			if (cmd.upd_inc) upd_q <= upd_q + 32'd1;
		end
	end

	assign addr = clr_en ? clr_q[AW-1:0] : AW'({RW'(cmd.row), bucket_q});
	assign we = clr_en || cmd.mem_wr;
	assign wdata = clr_en ? 32'd0 : cnt_q[cmd.row];

	cms_ram #(.WIDTH(32), .DEPTH(Depth)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	assign stat.hash_done = hdone;
	assign stat.op = op_q;
	assign stat.clr_done = clr_q[AW] | (clr_q[AW-1:0] == AW'(Depth - 1));
	assign strobe = cmd.emit;
	assign min_estimate = min_q;
	assign updates_seen = upd_q;
endmodule

@@ hdl/cms_ctrl.sv @@
// Controller: sequences clear sweep, per-row hashing, RAM access and result.
module cms_ctrl import cms_pkg::*; #(
	parameter int unsigned NUM_ROWS = TableDepthDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output logic      clr_en,
	input  cms_stat_t stat,
	output cms_cmd_t  cmd
);
	typedef enum logic [2:0] {S_CLR, S_IDLE, S_HASH, S_WAIT, S_ACC, S_CMP, S_EMIT} st_t;
	st_t st_q;
	logic [1:0] row_q;
	logic last;

	assign last = (row_q == 2'(NUM_ROWS - 1));

	// state register and row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			row_q <= '0;
		end else begin
			case (st_q)
				S_CLR: if (stat.clr_done) st_q <= S_IDLE;
				S_IDLE: if (start) begin
					row_q <= '0;
					st_q <= S_HASH;
				end
				S_HASH: st_q <= S_WAIT;
				S_WAIT: if (stat.hash_done) st_q <= S_ACC;
				S_ACC: begin
					if (stat.op == OP_ESTIMATE) st_q <= S_CMP;
					else if (last) st_q <= S_IDLE;
					else begin
						row_q <= row_q + 2'd1;
						st_q <= S_HASH;
					end
				end
				S_CMP: begin
					if (last) st_q <= S_EMIT;
					else begin
						row_q <= row_q + 2'd1;
						st_q <= S_HASH;
					end
				end
				S_EMIT: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.row = row_q;
		cmd.load = (st_q == S_IDLE) && start;
		cmd.hash_go = (st_q == S_HASH);
		cmd.mem_wr = (st_q == S_ACC) && (stat.op == OP_UPDATE);
		cmd.cmp = (st_q == S_CMP);
		cmd.emit = (st_q == S_EMIT);
		cmd.upd_inc = cmd.mem_wr && last;
	end

	assign busy = (st_q != S_IDLE);
	assign clr_en = (st_q == S_CLR);
endmodule

@@ hdl/sketch_counter_table_min_query_unit.sv @@
// Top level: count-min sketch with overwrite update and minimum estimate.
//  channel | signals                                      | direction
//  command | start, busy, opcode, item_key, count_row0..3 | in, busy out
//  result  | strobe, min_estimate, updates_seen           | out
//  config  | psel, penable, pwrite, paddr, pwdata, prdata | APB
// Each row: a hash start, the iterative hash and one RAM access, plus a compare on
// estimates (registered read). A new beat is taken only in idle, with busy low, so
// each beat is done before the next. Estimate: strobe in the last busy cycle.
// After reset a clearing sweep zeroes all NUM_ROWS << clog2(NUM_BUCKETS) RAM words
// (4096), busy high. Results appear for one cycle on strobe; no stall exists.
module sketch_counter_table_min_query_unit import cms_pkg::*; #(
	parameter int unsigned NUM_ROWS = TableDepthDefault,
	parameter int unsigned NUM_BUCKETS = TableWidthDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                opcode,
	input  logic [63:0]         item_key,
	input  logic [31:0]         count_row0,
	input  logic [31:0]         count_row1,
	input  logic [31:0]         count_row2,
	input  logic [31:0]         count_row3,
	output logic                strobe,
	output logic [31:0]         min_estimate,
	output logic [31:0]         updates_seen,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	cms_cmd_t cmd;
	cms_stat_t stat;
	logic clr_en;
	logic cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	cms_ctrl #(.NUM_ROWS(NUM_ROWS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.clr_en(clr_en), .stat(stat), .cmd(cmd)
	);

	cms_datapath #(
		.NUM_ROWS(NUM_ROWS), .NUM_BUCKETS(NUM_BUCKETS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .clr_en(clr_en),
		.opcode(opcode), .item_key(item_key), .count_row0(count_row0),
		.count_row1(count_row1), .count_row2(count_row2), .count_row3(count_row3),
		.cfg_we(cfg_we), .cfg_idx(paddr[4:2]), .cfg_wdata(pwdata),
		.cfg_rdata(prdata), .strobe(strobe), .min_estimate(min_estimate),
		.updates_seen(updates_seen)
	);
endmodule
